>>> hw/rtl/vmp_pkg.sv
// Package for the view message parser: phase and event codes, result record,
// configuration map and reset constants. No dependencies.
package vmp_pkg;

  // Configuration map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0] REG_EXPECTED_MAGIC = 1'b0;

  // ASCII "LSTV" as a little-endian word
  localparam logic [31:0] MAGIC_RESET = 32'h5654_534C;
  // Pad bytes after the done byte, counted from zero
  localparam logic [1:0] PAD_LAST = 2'd2;
  // Byte position that completes a 32-bit field
  localparam logic [1:0] FIELD_LAST = 2'd3;

  // Parse phases, one-hot
  typedef enum logic [8:0] {
    PH_MAGIC   = 9'b0_0000_0001,
    PH_TICK    = 9'b0_0000_0010,
    PH_REWARD  = 9'b0_0000_0100,
    PH_DONE    = 9'b0_0000_1000,
    PH_PAD     = 9'b0_0001_0000,
    PH_COUNT   = 9'b0_0010_0000,
    PH_BLEN    = 9'b0_0100_0000,
    PH_PAYLOAD = 9'b0_1000_0000,
    PH_TAIL    = 9'b1_0000_0000
  } vmp_phase_t;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_HEADER  = 2'd1,
    EV_BLOB    = 2'd2,
    EV_PAYLOAD = 2'd3
  } vmp_event_t;

  // One result item
  typedef struct packed {
    vmp_event_t  event_res;
    logic [31:0] tick;
    logic [31:0] reward_bits;
    logic        done_flag;
    logic [31:0] value_count;
    logic [31:0] blob_index;
    logic [31:0] blob_length;
    logic [7:0]  payload_byte;
    logic [31:0] byte_offset;
    logic        msg_end;
    logic        msg_ok;
  } vmp_result_t;

endpackage

>>> hw/rtl/vmp_if.sv
// Stream channel interfaces for the view message parser: byte input and
// result output. Depends on vmp_pkg.
interface vmp_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface vmp_out_if (input logic clk);
  import vmp_pkg::*;

  logic        valid;
  logic        ready;
  vmp_event_t  event_res;
  logic [31:0] tick;
  logic [31:0] reward_bits;
  logic        done_flag;
  logic [31:0] value_count;
  logic [31:0] blob_index;
  logic [31:0] blob_length;
  logic [7:0]  payload_byte;
  logic [31:0] byte_offset;
  logic        msg_end;
  logic        msg_ok;

  modport source (
    output valid, input ready,
    output event_res, output tick, output reward_bits, output done_flag,
    output value_count, output blob_index, output blob_length,
    output payload_byte, output byte_offset, output msg_end, output msg_ok
  );
  modport sink (
    input valid, output ready,
    input event_res, input tick, input reward_bits, input done_flag,
    input value_count, input blob_index, input blob_length,
    input payload_byte, input byte_offset, input msg_end, input msg_ok
  );
endinterface

>>> hw/rtl/vmp_cfg_regs.sv
// APB-style configuration register block holding the expected magic word.
// Depends on vmp_pkg.
module vmp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vmp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [vmp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [vmp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [31:0]                    magic
);
  import vmp_pkg::*;

  logic [31:0] magic_r;
  logic [31:0] magic_nxt;
  logic        reg_sel;
  logic        wr_en;

  // Register index is the word address
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_EXPECTED_MAGIC);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  // Take write data on the access cycle
  always_comb begin
    magic_nxt = magic_r;
    if (wr_en) begin
      magic_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
    end else begin
      magic_r <= magic_nxt;
    end
  end

  // Read back; unmapped addresses read zero
  assign prdata = (psel && reg_sel) ? magic_r : '0;
  assign magic  = magic_r;

endmodule

>>> hw/rtl/vmp_parse_core.sv
// Parse state and per-byte step logic: advances the phase machine on each
// accepted byte and forms the result item. Depends on vmp_pkg.
module vmp_parse_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 last,
  input  logic [31:0]          magic,
  output vmp_pkg::vmp_result_t res
);
  import vmp_pkg::*;

  vmp_phase_t  phase_r, phase_nxt;
  logic [1:0]  fbc_r, fbc_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] reward_r, reward_nxt;
  logic        done_r, done_nxt;
  logic [31:0] blobs_left_r, blobs_left_nxt;
  logic [31:0] cur_blob_r, cur_blob_nxt;
  logic [31:0] pay_left_r, pay_left_nxt;
  logic [31:0] pay_pos_r, pay_pos_nxt;
  logic        err_r, err_nxt;

  logic        field_done;
  logic [31:0] word;
  logic [31:0] fin_blobs_left;
  vmp_phase_t  fin_phase;
  logic [31:0] pay_left_dec;

  // Byte gather: completed word is the new byte over the three held ones
  assign field_done = (fbc_r == FIELD_LAST);
  assign word       = {data_byte, asm_r};

  // End of a blob: count down and pick the next phase
  assign fin_blobs_left = (blobs_left_r != '0) ? blobs_left_r - 32'd1 : blobs_left_r;
  assign fin_phase      = (fin_blobs_left == '0) ? PH_TAIL : PH_BLEN;
  assign pay_left_dec   = (pay_left_r != '0) ? pay_left_r - 32'd1 : pay_left_r;

  always_comb begin
    phase_nxt      = phase_r;
    fbc_nxt        = fbc_r;
    asm_nxt        = asm_r;
    tick_nxt       = tick_r;
    reward_nxt     = reward_r;
    done_nxt       = done_r;
    blobs_left_nxt = blobs_left_r;
    cur_blob_nxt   = cur_blob_r;
    pay_left_nxt   = pay_left_r;
    pay_pos_nxt    = pay_pos_r;
    err_nxt        = err_r;
    res            = '0;
    res.event_res  = EV_NONE;

    // Shift the byte into the assembly word for gathering phases
    if (phase_r inside {PH_MAGIC, PH_TICK, PH_REWARD, PH_COUNT, PH_BLEN}) begin
      case (fbc_r)
        2'd0:    asm_nxt = {16'h0000, data_byte};
        2'd1:    asm_nxt = {8'h00, data_byte, asm_r[7:0]};
        2'd2:    asm_nxt = {data_byte, asm_r[15:0]};
        default: asm_nxt = asm_r;
      endcase
      fbc_nxt = field_done ? 2'd0 : fbc_r + 2'd1;
    end

    // Advance the phase machine unless an error is pending
    if (!err_r) begin
      case (phase_r)
        PH_MAGIC: begin
          if (field_done) begin
            if (word != magic) begin
              err_nxt = 1'b1;
            end else begin
              phase_nxt = PH_TICK;
            end
          end
        end
        PH_TICK: begin
          if (field_done) begin
            tick_nxt  = word;
            phase_nxt = PH_REWARD;
          end
        end
        PH_REWARD: begin
          if (field_done) begin
            reward_nxt = word;
            phase_nxt  = PH_DONE;
          end
        end
        PH_DONE: begin
          done_nxt  = (data_byte != 8'h00);
          fbc_nxt   = 2'd0;
          phase_nxt = PH_PAD;
        end
        PH_PAD: begin
          if (fbc_r >= PAD_LAST) begin
            fbc_nxt   = 2'd0;
            phase_nxt = PH_COUNT;
          end else begin
            fbc_nxt = fbc_r + 2'd1;
          end
        end
        PH_COUNT: begin
          if (field_done) begin
            blobs_left_nxt  = word;
            cur_blob_nxt    = '0;
            res.event_res   = EV_HEADER;
            res.tick        = tick_r;
            res.reward_bits = reward_r;
            res.done_flag   = done_r;
            res.value_count = word;
            phase_nxt       = (word == '0) ? PH_TAIL : PH_BLEN;
          end
        end
        PH_BLEN: begin
          if (field_done) begin
            pay_left_nxt    = word;
            pay_pos_nxt     = '0;
            res.event_res   = EV_BLOB;
            res.blob_index  = cur_blob_r;
            res.blob_length = word;
            if (word == '0) begin
              cur_blob_nxt   = cur_blob_r + 32'd1;
              blobs_left_nxt = fin_blobs_left;
              fbc_nxt        = 2'd0;
              phase_nxt      = fin_phase;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          res.event_res    = EV_PAYLOAD;
          res.blob_index   = cur_blob_r;
          res.payload_byte = data_byte;
          res.byte_offset  = pay_pos_r;
          pay_pos_nxt      = pay_pos_r + 32'd1;
          pay_left_nxt     = pay_left_dec;
          if (pay_left_dec == '0) begin
            cur_blob_nxt   = cur_blob_r + 32'd1;
            blobs_left_nxt = fin_blobs_left;
            fbc_nxt        = 2'd0;
            phase_nxt      = fin_phase;
          end
        end
        default: begin
          // Trailing byte after the final blob
          err_nxt = 1'b1;
        end
      endcase
    end

    // Close the message and return to the start state
    if (last) begin
      res.msg_end    = 1'b1;
      res.msg_ok     = !err_nxt && (phase_nxt == PH_TAIL);
      phase_nxt      = PH_MAGIC;
      fbc_nxt        = '0;
      asm_nxt        = '0;
      tick_nxt       = '0;
      reward_nxt     = '0;
      done_nxt       = 1'b0;
      blobs_left_nxt = '0;
      cur_blob_nxt   = '0;
      pay_left_nxt   = '0;
      pay_pos_nxt    = '0;
      err_nxt        = 1'b0;
    end
  end

  // Update state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAGIC;
      fbc_r        <= '0;
      asm_r        <= '0;
      tick_r       <= '0;
      reward_r     <= '0;
      done_r       <= 1'b0;
      blobs_left_r <= '0;
      cur_blob_r   <= '0;
      pay_left_r   <= '0;
      pay_pos_r    <= '0;
      err_r        <= 1'b0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      fbc_r        <= fbc_nxt;
      asm_r        <= asm_nxt;
      tick_r       <= tick_nxt;
      reward_r     <= reward_nxt;
      done_r       <= done_nxt;
      blobs_left_r <= blobs_left_nxt;
      cur_blob_r   <= cur_blob_nxt;
      pay_left_r   <= pay_left_nxt;
      pay_pos_r    <= pay_pos_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

>>> hw/rtl/view_message_parser.sv
// View message parser top level: stream ports, output register and the
// configuration port. Depends on vmp_pkg, vmp_if, vmp_cfg_regs, vmp_parse_core.
//
// Takes one message byte per transfer and returns exactly one result per
// byte, in the cycle after the byte is accepted. A byte can be accepted every
// cycle: the parse step is a single pass through the phase machine, and the
// result register accepts a new result in the same cycle its current one is
// taken, so throughput is one byte per clock and in_ch.ready drops only
// while a result waits unclaimed. Change expected_magic only between
// messages, with no result outstanding.
module view_message_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  vmp_in_if.sink                         in_ch,
  vmp_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vmp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [vmp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [vmp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import vmp_pkg::*;

  logic        [31:0] magic;
  logic               in_xfer;
  vmp_result_t        step_res;
  vmp_result_t        res_r;
  logic               out_valid_r, out_valid_nxt;

  vmp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .magic   (magic)
  );

  vmp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_xfer),
    .data_byte (in_ch.data_byte),
    .last      (in_ch.last),
    .magic     (magic),
    .res       (step_res)
  );

  // Accept while the result slot is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result on each input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= step_res;
    end
  end

  // Drive the result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_res    = res_r.event_res;
  assign out_ch.tick         = res_r.tick;
  assign out_ch.reward_bits  = res_r.reward_bits;
  assign out_ch.done_flag    = res_r.done_flag;
  assign out_ch.value_count  = res_r.value_count;
  assign out_ch.blob_index   = res_r.blob_index;
  assign out_ch.blob_length  = res_r.blob_length;
  assign out_ch.payload_byte = res_r.payload_byte;
  assign out_ch.byte_offset  = res_r.byte_offset;
  assign out_ch.msg_end      = res_r.msg_end;
  assign out_ch.msg_ok       = res_r.msg_ok;

endmodule

>>> hw/rtl/vmp_checker.sv
// Port-level checks for the view message parser, bound to the top level.
// Depends on vmp_pkg.
module vmp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input vmp_pkg::vmp_event_t event_res,
  input logic [7:0]          payload_byte,
  input logic [31:0]         byte_offset,
  input logic                msg_end,
  input logic                msg_ok
);
  import vmp_pkg::*;

  // Stalled result holds its valid and event
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_res))
    else $error("result dropped or changed while stalled");

  // A waiting result blocks new input
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result slot full");

  // Every accepted byte yields a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte gave no result");

  // Status only on the message end
  a_ok_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !msg_end |-> !msg_ok)
    else $error("msg_ok without msg_end");

  // Payload fields are zero outside payload events
  a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res != EV_PAYLOAD |-> payload_byte == 8'h00 && byte_offset == '0)
    else $error("payload fields set on a non-payload event");

endmodule

bind view_message_parser vmp_checker u_vmp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .event_res    (out_ch.event_res),
  .payload_byte (out_ch.payload_byte),
  .byte_offset  (out_ch.byte_offset),
  .msg_end      (out_ch.msg_end),
  .msg_ok       (out_ch.msg_ok)
);
